/* rtl/bfds_pkg.sv */
// Package for the back-to-front distance sorter: request and result types,
// queue entry type, register codes and sizing constants.
// No dependencies.
package bfds_pkg;

	localparam int COORD_W             = 16;
	localparam int KEY_W               = 36;
	localparam int SQ_W                = 32;
	localparam int CFG_IDX_W           = 2;
	localparam int MAX_OBJECTS_DEFAULT = 64;
	localparam int QUEUE_DEPTH         = 4;
	localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAMERA_X = 2'd0,
		REG_CAMERA_Y = 2'd1,
		REG_CAMERA_Z = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} back_state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic                      last_object;
	} in_item_t;

	typedef struct packed {
		logic [5:0] object_index;
		logic       last_index;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             last;
	} qentry_t;

	typedef struct packed {
		logic    valid;
		qentry_t entry;
	} push_t;

endpackage

/* rtl/back_to_front_distance_sorter.sv */
// Top level of the back-to-front distance sorter: front end, request queue, sorter.
// Depends on bfds_pkg, bfds_front, bfds_queue, bfds_back.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+--------------------------------
//  request   | start / busy             | item   (bfds_pkg::in_item_t)
//  result    | result_valid (strobe)    | result (bfds_pkg::result_t)
//  config    | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// A request is taken each cycle while the key stage and queue hold fewer than four;
// its key is registered, then queued, then inserted while the sorter loads.
// After a last request, N held objects drain at one result per cycle; the first result
// follows that request through key stage, queue, chain and result register.
// During the drain the queue takes requests until full, then busy holds the sender.
// Reset clears control state only; no clearing pass. The receiver cannot stall.
module back_to_front_distance_sorter #(
	parameter int MAX_OBJECTS = bfds_pkg::MAX_OBJECTS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  bfds_pkg::in_item_t             item,
	output logic                           result_valid,
	output bfds_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bfds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfds_pkg::COORD_W-1:0]   cfg_data
);

	bfds_pkg::push_t                  push;
	bfds_pkg::qentry_t                q_head;
	logic                             q_valid;
	logic                             q_pop;
	logic [bfds_pkg::QUEUE_CNT_W-1:0] q_count;

	bfds_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_count   (q_count),
		.push      (push)
	);

	bfds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head),
		.count     (q_count)
	);

	bfds_back #(
		.MAX_OBJECTS (MAX_OBJECTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result       (result)
	);

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && !q_pop
		  && q_count == bfds_pkg::QUEUE_CNT_W'(bfds_pkg::QUEUE_DEPTH)))
		else $error("request queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= bfds_pkg::QUEUE_CNT_W'(bfds_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");

	a_run_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_index |=> !result_valid)
		else $error("result emitted straight after end of run");
`endif

endmodule

/* rtl/bfds_front.sv */
// Front end: camera registers, request acceptance and squared distance key.
// Depends on bfds_pkg.
module bfds_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  bfds_pkg::in_item_t                 item,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bfds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfds_pkg::COORD_W-1:0]       cfg_data,
	input  logic [bfds_pkg::QUEUE_CNT_W-1:0]   q_count,
	output bfds_pkg::push_t                    push
);

	logic [bfds_pkg::COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;
	logic                         valid_s1;
	logic                         last_s1;
	logic [bfds_pkg::SQ_W-1:0]    sq_x_s1, sq_y_s1, sq_z_s1;
	logic                         accept;
	logic [bfds_pkg::COORD_W-1:0] mag_x, mag_y, mag_z;
	logic [bfds_pkg::QUEUE_CNT_W:0] in_flight;

	function automatic logic [bfds_pkg::COORD_W-1:0] axis_mag(
		input logic [bfds_pkg::COORD_W-1:0] pos,
		input logic [bfds_pkg::COORD_W-1:0] cam
	);
		logic [bfds_pkg::COORD_W:0] d;
		logic [bfds_pkg::COORD_W:0] m;
		d = {pos[bfds_pkg::COORD_W-1], pos} - {cam[bfds_pkg::COORD_W-1], cam};
		m = d[bfds_pkg::COORD_W] ? (~d + 1'b1) : d;
		return m[bfds_pkg::COORD_W-1:0];
	endfunction

	assign cfg_ready = 1'b1;
	assign in_flight = (bfds_pkg::QUEUE_CNT_W + 1)'(q_count)
	                 + (bfds_pkg::QUEUE_CNT_W + 1)'(valid_s1);
	assign busy      = in_flight >= (bfds_pkg::QUEUE_CNT_W + 1)'(bfds_pkg::QUEUE_DEPTH);
	assign accept    = start && !busy;

	assign mag_x = axis_mag(item.pos_x, cam_x_q);
	assign mag_y = axis_mag(item.pos_y, cam_y_q);
	assign mag_z = axis_mag(item.pos_z, cam_z_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bfds_pkg::REG_CAMERA_X: cam_x_q <= cfg_data;
				bfds_pkg::REG_CAMERA_Y: cam_y_q <= cfg_data;
				bfds_pkg::REG_CAMERA_Z: cam_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sq_x_s1 <= mag_x * mag_x;
			sq_y_s1 <= mag_y * mag_y;
			sq_z_s1 <= mag_z * mag_z;
			last_s1 <= item.last_object;
		end
	end

	always_comb begin
		push.valid      = valid_s1;
		push.entry.last = last_s1;
		push.entry.key  = bfds_pkg::KEY_W'(sq_x_s1) + bfds_pkg::KEY_W'(sq_y_s1)
		                + bfds_pkg::KEY_W'(sq_z_s1);
	end

endmodule

/* rtl/bfds_queue.sv */
// Short FIFO of keyed requests between front end and sorter.
// Depends on bfds_pkg.
module bfds_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bfds_pkg::push_t                  push,
	input  logic                             pop,
	output logic                             not_empty,
	output bfds_pkg::qentry_t                head,
	output logic [bfds_pkg::QUEUE_CNT_W-1:0] count
);

	bfds_pkg::qentry_t                mem_q [bfds_pkg::QUEUE_DEPTH];
	logic [bfds_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [bfds_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                             do_pop;

	assign not_empty = count_q != '0;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == bfds_pkg::QUEUE_PTR_W'(bfds_pkg::QUEUE_DEPTH - 1))
				          ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == bfds_pkg::QUEUE_PTR_W'(bfds_pkg::QUEUE_DEPTH - 1))
				          ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + bfds_pkg::QUEUE_CNT_W'(push.valid)
			         - bfds_pkg::QUEUE_CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

endmodule

/* rtl/bfds_back.sv */
// Back end: insertion chain kept in descending key order, drained from the head.
// Depends on bfds_pkg.
module bfds_back #(
	parameter int MAX_OBJECTS = bfds_pkg::MAX_OBJECTS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  bfds_pkg::qentry_t q_head,
	output logic              q_pop,
	output logic              result_valid,
	output bfds_pkg::result_t result
);

	localparam int CW = $clog2(MAX_OBJECTS + 1);
	localparam int IW = $clog2(MAX_OBJECTS);
	localparam int XW = IW + 6;

	logic [bfds_pkg::KEY_W-1:0] key_q  [MAX_OBJECTS];
	logic [IW-1:0]              idx_q  [MAX_OBJECTS];
	logic [bfds_pkg::KEY_W-1:0] key_prev [MAX_OBJECTS];
	logic [IW-1:0]              idx_prev [MAX_OBJECTS];
	logic [bfds_pkg::KEY_W-1:0] key_next [MAX_OBJECTS];
	logic [IW-1:0]              idx_next [MAX_OBJECTS];
	logic [MAX_OBJECTS-1:0]     ge;
	logic [MAX_OBJECTS-1:0]     ge_prev;

	logic [CW-1:0]          count_q, count_d;
	bfds_pkg::back_state_t  state_q, state_d;
	logic                   insert_en;
	logic                   drain_en;
	logic [IW-1:0]          new_idx;
	logic [XW-1:0]          idx_ext;
	logic                   result_valid_q;
	bfds_pkg::result_t      result_q;

	assign new_idx = count_q[IW-1:0];

	for (genvar g = 0; g < MAX_OBJECTS; g++) begin : g_cell
		assign ge[g] = (CW'(g) < count_q) && (key_q[g] >= q_head.key);

		if (g == 0) begin : g_head
			assign ge_prev[g]  = 1'b1;
			assign key_prev[g] = '0;
			assign idx_prev[g] = '0;
		end else begin : g_body
			assign ge_prev[g]  = ge[g-1];
			assign key_prev[g] = key_q[g-1];
			assign idx_prev[g] = idx_q[g-1];
		end

		if (g == MAX_OBJECTS - 1) begin : g_tail
			assign key_next[g] = key_q[g];
			assign idx_next[g] = idx_q[g];
		end else begin : g_mid
			assign key_next[g] = key_q[g+1];
			assign idx_next[g] = idx_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (insert_en) begin
				if (!ge[g]) begin
					if (ge_prev[g]) begin
						key_q[g] <= q_head.key;
						idx_q[g] <= new_idx;
					end else begin
						key_q[g] <= key_prev[g];
						idx_q[g] <= idx_prev[g];
					end
				end
			end else if (drain_en) begin
				key_q[g] <= key_next[g];
				idx_q[g] <= idx_next[g];
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		q_pop     = 1'b0;
		insert_en = 1'b0;
		drain_en  = 1'b0;
		case (state_q)
			bfds_pkg::ST_LOAD: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (count_q < CW'(MAX_OBJECTS)) begin
						insert_en = 1'b1;
						count_d   = count_q + 1'b1;
					end
					if (q_head.last) begin
						state_d = bfds_pkg::ST_DRAIN;
					end
				end
			end
			bfds_pkg::ST_DRAIN: begin
				drain_en = 1'b1;
				count_d  = count_q - 1'b1;
				if (count_q == CW'(1)) begin
					state_d = bfds_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = bfds_pkg::ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bfds_pkg::ST_LOAD;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			count_q        <= count_d;
			result_valid_q <= drain_en;
		end
	end

	assign idx_ext = XW'(idx_q[0]);

	always_ff @(posedge clk) begin
		if (drain_en) begin
			result_q.object_index <= idx_ext[5:0];
			result_q.last_index   <= count_q == CW'(1);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
